@@ rtl/plsl_pkg.sv @@
// Types, constants and the reset curve shared by the sensor linearizer
`timescale 1ns / 1ps
`default_nettype none

package plsl_pkg;

    localparam int ADC_W  = 12;
    localparam int VAL_W  = 16;
    localparam int PIDX_W = 6;
    localparam int CNT_W  = 7;
    localparam int CFG_W  = 16;
    localparam int CFGI_W = 3;
    localparam int TIDX_W = 8;

    localparam int NUM_W  = 28;
    localparam int DEN_W  = 12;
    localparam int PROD_W = 30;

    localparam logic MODE_CONVERT = 1'b0;
    localparam logic MODE_WRITE   = 1'b1;

    localparam logic [ADC_W-1:0] LOW_LIMIT_RST  = 12'd700;
    localparam logic [ADC_W-1:0] HIGH_LIMIT_RST = 12'd936;
    localparam logic [VAL_W-1:0] LOW_VALUE_RST  = 16'd1000;
    localparam logic [VAL_W-1:0] HIGH_VALUE_RST = 16'd40000;
    localparam logic [CNT_W-1:0] POINT_CNT_RST  = 7'd37;

    localparam int CURVE_POINTS     = 37;
    localparam int CURVE_VALUE_BASE = 4000;
    localparam int CURVE_VALUE_STEP = 1000;

    localparam logic [ADC_W-1:0] CURVE_ADC [CURVE_POINTS] = '{
        12'd750, 12'd754, 12'd760, 12'd764, 12'd770, 12'd774, 12'd778, 12'd784,
        12'd788, 12'd794, 12'd798, 12'd804, 12'd810, 12'd816, 12'd820, 12'd826,
        12'd832, 12'd836, 12'd842, 12'd848, 12'd854, 12'd858, 12'd864, 12'd868,
        12'd872, 12'd878, 12'd882, 12'd888, 12'd892, 12'd898, 12'd902, 12'd908,
        12'd914, 12'd918, 12'd924, 12'd930, 12'd936
    };

    typedef enum logic [CFGI_W-1:0] {
        CFG_LOW_LIMIT,
        CFG_HIGH_LIMIT,
        CFG_LOW_VALUE,
        CFG_HIGH_VALUE,
        CFG_POINT_COUNT
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_CHECK,
        ST_MUL,
        ST_DIV,
        ST_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [ADC_W-1:0] adc;
        logic [VAL_W-1:0] value;
    } entry_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quot;
    } div_rsp_t;

    function automatic entry_t reset_entry(input logic [TIDX_W-1:0] k);
        entry_t     e;
        logic [5:0] k6;
        k6 = k[5:0];
        e  = '0;
        if (int'(k) < CURVE_POINTS)
        begin
            e.adc   = CURVE_ADC[k6];
            e.value = VAL_W'(CURVE_VALUE_BASE + CURVE_VALUE_STEP * int'(k6));
        end
        return e;
    endfunction

endpackage

`default_nettype wire

@@ rtl/plsl_req_if.sv @@
// Request channel: convert or table-write item with valid/ready handshake
`timescale 1ns / 1ps
`default_nettype none

interface plsl_req_if;
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic [plsl_pkg::ADC_W-1:0]    sample;
    logic [plsl_pkg::PIDX_W-1:0]   point_index;
    logic [plsl_pkg::ADC_W-1:0]    point_adc;
    logic [plsl_pkg::VAL_W-1:0]    point_value;

    modport source (
        output valid, mode, sample, point_index, point_adc, point_value,
        input  ready
    );

    modport sink (
        input  valid, mode, sample, point_index, point_adc, point_value,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/plsl_rsp_if.sv @@
// Result channel: linearized value and fault flag with valid/ready handshake
`timescale 1ns / 1ps
`default_nettype none

interface plsl_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [plsl_pkg::VAL_W-1:0] value;
    logic                       fault;

    modport source (
        output valid, value, fault,
        input  ready
    );

    modport sink (
        input  valid, value, fault,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/plsl_ram.sv @@
// Generic RAM: one write port, two registered read ports
`timescale 1ns / 1ps
`default_nettype none

module plsl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic      [WIDTH-1:0]         rd_data_a,
    output logic      [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

`default_nettype wire

@@ rtl/plsl_table.sv @@
// Point table: RAM with per-entry valid bits falling back to the reset curve
`timescale 1ns / 1ps
`default_nettype none

module plsl_table #(
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire plsl_pkg::entry_t         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_lo,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_hi,
    output plsl_pkg::entry_t              rd_lo,
    output plsl_pkg::entry_t              rd_hi
);

    localparam int AW = $clog2(DEPTH);

    logic [DEPTH-1:0]  valid_reg;
    logic              lo_valid_reg;
    logic              hi_valid_reg;
    logic [AW-1:0]     lo_addr_reg;
    logic [AW-1:0]     hi_addr_reg;
    logic [$bits(plsl_pkg::entry_t)-1:0] ram_lo;
    logic [$bits(plsl_pkg::entry_t)-1:0] ram_hi;

    plsl_ram #(
        .WIDTH ($bits(plsl_pkg::entry_t)),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr_a (rd_addr_lo),
        .rd_addr_b (rd_addr_hi),
        .rd_data_a (ram_lo),
        .rd_data_b (ram_hi)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            lo_valid_reg <= valid_reg[rd_addr_lo];
            hi_valid_reg <= valid_reg[rd_addr_hi];
            lo_addr_reg  <= rd_addr_lo;
            hi_addr_reg  <= rd_addr_hi;
        end
    end

    always_comb
    begin
        rd_lo = lo_valid_reg ? plsl_pkg::entry_t'(ram_lo)
                             : plsl_pkg::reset_entry(plsl_pkg::TIDX_W'(lo_addr_reg));
        rd_hi = hi_valid_reg ? plsl_pkg::entry_t'(ram_hi)
                             : plsl_pkg::reset_entry(plsl_pkg::TIDX_W'(hi_addr_reg));
    end

endmodule

`default_nettype wire

@@ rtl/plsl_divider.sv @@
// Restoring unsigned divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module plsl_divider (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire plsl_pkg::div_req_t req,
    output plsl_pkg::div_rsp_t      rsp
);

    localparam int NW  = plsl_pkg::NUM_W;
    localparam int DW  = plsl_pkg::DEN_W;
    localparam int CW  = $clog2(NW);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [NW-1:0] quo_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] den_reg;
    logic [DW:0]   rem_shift;
    logic [DW:0]   rem_trial;
    logic          take;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[NW-1]};
        rem_trial = rem_shift - {1'b0, den_reg};
        take      = (rem_shift >= {1'b0, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !req.start && (cnt_reg == '0);
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW - 1);
            end
            else if (busy_reg)
            begin
                busy_reg <= (cnt_reg != '0);
                cnt_reg  <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.num;
            rem_reg <= '0;
            den_reg <= req.den;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NW-2:0], take};
            rem_reg <= take ? rem_trial[DW-1:0] : rem_shift[DW-1:0];
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;

endmodule

`default_nettype wire

@@ rtl/piecewise_linear_sensor_linearizer_core.sv @@
// Sensor linearizer top level: limit checks, segment walk, interpolation
// Table write: no result; limit convert: result in the cycle after accept.
// Inside the limits: per segment visited a RAM read (FETCH) and a compare (CHECK), then
// multiply (MUL), divider start (DIV), divider wait (WAIT) and output (DONE); an exact
// hit or zero-width segment goes straight to output; one item at a time, next once the result frees.
// Reset restores the register defaults and the 37-point curve at once.
`timescale 1ns / 1ps
`default_nettype none

module piecewise_linear_sensor_linearizer_core #(
    parameter int MAX_POINTS = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    plsl_req_if.sink                           req,
    plsl_rsp_if.source                         rsp,
    input  wire logic                          cfg_we,
    input  wire logic [plsl_pkg::CFGI_W-1:0]   cfg_index,
    input  wire logic [plsl_pkg::CFG_W-1:0]    cfg_data
);

    localparam int AW  = $clog2(MAX_POINTS);
    localparam int SW  = $clog2(MAX_POINTS + 1);
    localparam int PW  = (plsl_pkg::CNT_W > SW) ? plsl_pkg::CNT_W : SW;
    localparam int ADW = plsl_pkg::ADC_W;
    localparam int VW  = plsl_pkg::VAL_W;
    localparam int PRW = plsl_pkg::PROD_W;

    plsl_pkg::state_t state_reg;
    plsl_pkg::state_t state_next;

    logic [ADW-1:0]         low_limit_reg;
    logic [ADW-1:0]         high_limit_reg;
    logic [VW-1:0]          low_value_reg;
    logic [VW-1:0]          high_value_reg;
    logic [plsl_pkg::CNT_W-1:0] point_count_reg;

    logic [AW-1:0]          cursor_reg, cursor_next;
    logic                   fault_reg, fault_next;
    logic [AW-1:0]          idx_reg, idx_next;
    logic [SW-1:0]          steps_reg, steps_next;
    logic                   out_valid_reg, out_valid_next;
    logic [VW-1:0]          out_value_reg, out_value_next;
    logic                   out_fault_reg, out_fault_next;

    logic [ADW-1:0]         s_reg, s_next;
    logic [VW-1:0]          vlo_reg, vlo_next;
    logic signed [VW:0]     dy_reg, dy_next;
    logic signed [ADW:0]    dx_reg, dx_next;
    logic signed [ADW:0]    den_reg, den_next;
    logic signed [PRW-1:0]  prod_reg, prod_next;
    logic                   neg_reg, neg_next;
    logic [VW-1:0]          res_reg, res_next;

    logic [PW-1:0]          pc_ext;
    logic [PW-1:0]          pts_used;
    logic [AW-1:0]          last_seg;
    logic [AW-1:0]          start_idx;

    logic                   accept;
    logic                   is_convert;
    logic                   is_low;
    logic                   is_high;
    logic                   out_free;

    plsl_pkg::entry_t       ent_lo;
    plsl_pkg::entry_t       ent_hi;
    plsl_pkg::entry_t       wr_entry;
    logic                   tbl_wr_en;
    logic                   tbl_rd_en;

    logic                   seg_hit;
    logic                   go_up;
    logic                   walk_stop;
    logic                   direct;

    plsl_pkg::div_req_t     div_req;
    plsl_pkg::div_rsp_t     div_rsp;

    logic signed [PRW-1:0]  prod_abs;
    logic signed [PRW-1:0]  quot_s;
    logic signed [PRW-1:0]  interp;

    // ---------------------------------------------------------------
    always_comb
    begin
        pc_ext = PW'(point_count_reg);
        if (pc_ext < PW'(2))
        begin
            pts_used = PW'(2);
        end
        else if (pc_ext > PW'(MAX_POINTS))
        begin
            pts_used = PW'(MAX_POINTS);
        end
        else
        begin
            pts_used = pc_ext;
        end
        last_seg  = AW'(pts_used - PW'(2));
        start_idx = (cursor_reg > last_seg) ? last_seg : cursor_reg;
    end

    assign out_free   = !out_valid_reg || rsp.ready;
    assign req.ready  = (state_reg == plsl_pkg::ST_IDLE) && out_free;
    assign accept     = req.valid && req.ready;
    assign is_convert = (req.mode == plsl_pkg::MODE_CONVERT);
    assign is_low     = (req.sample <= low_limit_reg);
    assign is_high    = (req.sample >= high_limit_reg);

    always_comb
    begin
        seg_hit   = (s_reg >= ent_lo.adc) && (s_reg < ent_hi.adc);
        go_up     = (s_reg > ent_lo.adc);
        walk_stop = (steps_reg == SW'(MAX_POINTS)) || seg_hit
                    || (go_up && (idx_reg >= last_seg))
                    || (!go_up && (idx_reg == '0));
        direct    = (s_reg == ent_lo.adc) || (ent_hi.adc == ent_lo.adc);
    end

    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            plsl_pkg::ST_IDLE:
            begin
                if (accept && is_convert && !is_low && !is_high)
                begin
                    state_next = plsl_pkg::ST_FETCH;
                end
            end
            plsl_pkg::ST_FETCH:
            begin
                state_next = plsl_pkg::ST_CHECK;
            end
            plsl_pkg::ST_CHECK:
            begin
                if (!walk_stop)
                begin
                    state_next = plsl_pkg::ST_FETCH;
                end
                else if (direct)
                begin
                    state_next = plsl_pkg::ST_DONE;
                end
                else
                begin
                    state_next = plsl_pkg::ST_MUL;
                end
            end
            plsl_pkg::ST_MUL:
            begin
                state_next = plsl_pkg::ST_DIV;
            end
            plsl_pkg::ST_DIV:
            begin
                state_next = plsl_pkg::ST_WAIT;
            end
            plsl_pkg::ST_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = plsl_pkg::ST_DONE;
                end
            end
            plsl_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = plsl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = plsl_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    always_comb
    begin
        prod_abs = prod_reg[PRW-1] ? -prod_reg : prod_reg;

        tbl_wr_en        = accept && (req.mode == plsl_pkg::MODE_WRITE)
                           && (int'(req.point_index) < MAX_POINTS);
        wr_entry.adc     = req.point_adc;
        wr_entry.value   = req.point_value;
        tbl_rd_en        = (state_reg == plsl_pkg::ST_FETCH);

        div_req.start    = (state_reg == plsl_pkg::ST_DIV);
        div_req.num      = prod_abs[plsl_pkg::NUM_W-1:0];
        div_req.den      = den_reg[ADW] ? ADW'(-den_reg) : den_reg[ADW-1:0];
    end

    // ---------------------------------------------------------------
    always_comb
    begin
        cursor_next    = cursor_reg;
        fault_next     = fault_reg;
        idx_next       = idx_reg;
        steps_next     = steps_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_fault_next = out_fault_reg;
        s_next         = s_reg;
        vlo_next       = vlo_reg;
        dy_next        = dy_reg;
        dx_next        = dx_reg;
        den_next       = den_reg;
        prod_next      = prod_reg;
        neg_next       = neg_reg;
        res_next       = res_reg;
        quot_s         = '0;
        interp         = '0;

        if (rsp.valid && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            plsl_pkg::ST_IDLE:
            begin
                if (accept && is_convert)
                begin
                    if (is_low)
                    begin
                        fault_next     = 1'b1;
                        out_valid_next = 1'b1;
                        out_value_next = low_value_reg;
                        out_fault_next = 1'b1;
                    end
                    else if (is_high)
                    begin
                        out_valid_next = 1'b1;
                        out_value_next = high_value_reg;
                        out_fault_next = fault_reg;
                    end
                    else
                    begin
                        fault_next = 1'b0;
                        s_next     = req.sample;
                        idx_next   = start_idx;
                        steps_next = '0;
                    end
                end
            end
            plsl_pkg::ST_CHECK:
            begin
                if (!walk_stop)
                begin
                    idx_next   = go_up ? idx_reg + 1'b1 : idx_reg - 1'b1;
                    steps_next = steps_reg + 1'b1;
                end
                else
                begin
                    cursor_next = idx_reg;
                    res_next    = ent_lo.value;
                    vlo_next    = ent_lo.value;
                    dy_next     = $signed({1'b0, ent_hi.value}) - $signed({1'b0, ent_lo.value});
                    dx_next     = $signed({1'b0, s_reg}) - $signed({1'b0, ent_lo.adc});
                    den_next    = $signed({1'b0, ent_hi.adc}) - $signed({1'b0, ent_lo.adc});
                end
            end
            plsl_pkg::ST_MUL:
            begin
                prod_next = dy_reg * dx_reg;
            end
            plsl_pkg::ST_DIV:
            begin
                neg_next = prod_reg[PRW-1] ^ den_reg[ADW];
            end
            plsl_pkg::ST_WAIT:
            begin
                if (div_rsp.done)
                begin
                    quot_s = $signed({2'b00, div_rsp.quot});
                    if (neg_reg)
                    begin
                        quot_s = -quot_s;
                    end
                    interp = $signed(PRW'(vlo_reg)) + quot_s;
                    if (interp < 0)
                    begin
                        res_next = '0;
                    end
                    else if (interp > $signed(PRW'(16'hFFFF)))
                    begin
                        res_next = '1;
                    end
                    else
                    begin
                        res_next = interp[VW-1:0];
                    end
                end
            end
            plsl_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = res_reg;
                    out_fault_next = fault_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= plsl_pkg::ST_IDLE;
            cursor_reg      <= '0;
            fault_reg       <= 1'b0;
            idx_reg         <= '0;
            steps_reg       <= '0;
            out_valid_reg   <= 1'b0;
            low_limit_reg   <= plsl_pkg::LOW_LIMIT_RST;
            high_limit_reg  <= plsl_pkg::HIGH_LIMIT_RST;
            low_value_reg   <= plsl_pkg::LOW_VALUE_RST;
            high_value_reg  <= plsl_pkg::HIGH_VALUE_RST;
            point_count_reg <= plsl_pkg::POINT_CNT_RST;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            fault_reg     <= fault_next;
            idx_reg       <= idx_next;
            steps_reg     <= steps_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    plsl_pkg::CFG_LOW_LIMIT:   low_limit_reg   <= cfg_data[ADW-1:0];
                    plsl_pkg::CFG_HIGH_LIMIT:  high_limit_reg  <= cfg_data[ADW-1:0];
                    plsl_pkg::CFG_LOW_VALUE:   low_value_reg   <= cfg_data[VW-1:0];
                    plsl_pkg::CFG_HIGH_VALUE:  high_value_reg  <= cfg_data[VW-1:0];
                    plsl_pkg::CFG_POINT_COUNT: point_count_reg <= cfg_data[plsl_pkg::CNT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
        out_fault_reg <= out_fault_next;
        s_reg         <= s_next;
        vlo_reg       <= vlo_next;
        dy_reg        <= dy_next;
        dx_reg        <= dx_next;
        den_reg       <= den_next;
        prod_reg      <= prod_next;
        neg_reg       <= neg_next;
        res_reg       <= res_next;
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.value = out_value_reg;
    assign rsp.fault = out_fault_reg;

    // ---------------------------------------------------------------
    plsl_table #(
        .DEPTH (MAX_POINTS)
    ) u_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (tbl_wr_en),
        .wr_addr    (AW'(req.point_index)),
        .wr_data    (wr_entry),
        .rd_en      (tbl_rd_en),
        .rd_addr_lo (idx_reg),
        .rd_addr_hi (idx_reg + 1'b1),
        .rd_lo      (ent_lo),
        .rd_hi      (ent_hi)
    );

    plsl_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

`ifndef SYNTHESIS
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= AW'(MAX_POINTS - 2))
        else $error("segment cursor beyond last table segment");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == plsl_pkg::ST_CHECK) |-> (idx_reg <= last_seg))
        else $error("segment walk left the table");

    a_low_fault: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_convert && is_low)
        |=> (rsp.valid && rsp.fault && (rsp.value == $past(low_value_reg))))
        else $error("low sample did not report fault result");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == plsl_pkg::ST_WAIT))
        else $error("divider finished outside the wait state");
`endif

endmodule

`default_nettype wire
